>>> hw/rtl/wsli_pkg.sv
// shared types, constants and helpers for the word-size limited integer alu
// no dependencies
`timescale 1ns / 1ps

package wsli_pkg;

	localparam int unsigned DataWidth = 64;
	localparam int unsigned WsWidth   = 6;
	localparam int unsigned NumCells  = DataWidth;
	localparam logic [WsWidth-1:0] WordSizeReset = 6'd63;

	typedef enum logic [3:0] {
		ACT_OR  = 4'd0,
		ACT_AND = 4'd1,
		ACT_XOR = 4'd2,
		ACT_LSL = 4'd3,
		ACT_LSR = 4'd4,
		ACT_ASR = 4'd5,
		ACT_ADD = 4'd6,
		ACT_SUB = 4'd7,
		ACT_MUL = 4'd8,
		ACT_DIV = 4'd9
	} action_e;

	// record that travels down the divider chain
	typedef struct packed {
		logic                 valid;
		logic                 is_div;
		logic                 q_neg;
		logic                 dz;
		logic [DataWidth-1:0] rem;
		logic [DataWidth-1:0] quo;
		logic [DataWidth-1:0] dvs;
	} div_rec_t;

	// bits above the sign position
	function automatic logic [DataWidth-1:0] high_mask(input logic [WsWidth-1:0] w);
		high_mask = ({DataWidth{1'b1}} << w) << 1;
	endfunction

	function automatic logic [DataWidth-1:0] wrap_word(input logic [DataWidth-1:0] v,
			input logic [WsWidth-1:0] w);
		logic [DataWidth-1:0] hi;
		hi = high_mask(w);
		wrap_word = v[w] ? (v | hi) : (v & ~hi);
	endfunction

endpackage

>>> hw/rtl/wsli_if.sv
// request and result channel interfaces
// depends on wsli_pkg
`timescale 1ns / 1ps

interface wsli_op_if;
	logic        valid;
	logic        ready;
	logic [3:0]  action;
	logic signed [wsli_pkg::DataWidth-1:0] operand_a;
	logic signed [wsli_pkg::DataWidth-1:0] operand_b;
	modport source (output valid, action, operand_a, operand_b, input ready);
	modport sink (input valid, action, operand_a, operand_b, output ready);
endinterface

interface wsli_res_if;
	logic        valid;
	logic        ready;
	logic signed [wsli_pkg::DataWidth-1:0] result_value;
	logic        error_code;
	modport source (output valid, result_value, error_code, input ready);
	modport sink (input valid, result_value, error_code, output ready);
endinterface

>>> hw/rtl/word_size_limited_integer_alu_top.sv
// top level of the word-size limited integer alu
// depends on wsli_pkg, wsli_if, wsli_front, wsli_div_cell
`timescale 1ns / 1ps

// Takes one request per cycle (action, operand_a, operand_b) and returns one
// result per request, in order. The path is an input holding register, two
// front stages (logic, shifts, add/sub and 32x32 partial products of the
// multiply), a row of 64 identical divider cells that each produce one
// quotient bit, and an output register; every request walks the whole row so
// ordering is kept. Throughput is one request per clock; the row stalls as a
// whole only while the output register holds a result that is not taken, and
// the input register still absorbs one more request during such a stall.
// Results are wrapped to word_size+1 bits and sign-extended; divide by zero
// returns 0 with error_code set. word_size resets to 63 and may only be
// written while no request is in flight.
module word_size_limited_integer_alu_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         word_size_we,
	input  logic [wsli_pkg::WsWidth-1:0] word_size_wdata,
	wsli_op_if.sink                      op_chan,
	wsli_res_if.source                   res_chan
);
	localparam int unsigned W = wsli_pkg::DataWidth;
	localparam int unsigned N = wsli_pkg::NumCells;

	logic [wsli_pkg::WsWidth-1:0] word_size_q;
	logic                         en, accept;

	// input holding register
	logic         in_valid_q;
	logic [3:0]   action_q;
	logic [W-1:0] operand_a_q, operand_b_q;

	// record chain: index 0 is the front output, index N the last cell
	wsli_pkg::div_rec_t chain [N+1];

	// output register
	logic         out_valid_q, out_err_q;
	logic [W-1:0] out_result_q, final_v, fin_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_size_q <= wsli_pkg::WordSizeReset;
		end else if (word_size_we) begin
			word_size_q <= word_size_wdata;
		end
	end

	// whole row moves when the output slot is free or being emptied
	assign en     = !out_valid_q || res_chan.ready;
	assign op_chan.ready = !in_valid_q || en;
	assign accept = op_chan.valid && op_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_q <= 1'b0;
		end else if (en) begin
			in_valid_q <= accept;
		end else if (accept) begin
			in_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q    <= op_chan.action;
			operand_a_q <= op_chan.operand_a;
			operand_b_q <= op_chan.operand_b;
		end
	end

	wsli_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid_q),
		.action    (action_q),
		.operand_a (operand_a_q),
		.operand_b (operand_b_q),
		.word_size (word_size_q),
		.rec       (chain[0])
	);

	// one quotient bit per cell
	for (genvar i = 0; i < N; i++) begin : g_cell
		wsli_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.rec_in  (chain[i]),
			.rec_out (chain[i+1])
		);
	end

	// sign fix for division, then wrap; divide by zero forces zero
	always_comb begin
		fin_quo = chain[N].quo;
		if (chain[N].is_div && chain[N].q_neg) begin
			fin_quo = ~chain[N].quo + 1'b1;
		end
		final_v = chain[N].dz ? '0 : wsli_pkg::wrap_word(fin_quo, word_size_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= chain[N].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_result_q <= final_v;
			out_err_q    <= chain[N].dz;
		end
	end

	assign res_chan.valid        = out_valid_q;
	assign res_chan.result_value = out_result_q;
	assign res_chan.error_code   = out_err_q;

	// an error result always carries zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_err_q |-> out_result_q == '0)
		else $error("error result not zero");

	// results are sign-extended above the sign position
	a_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_result_q ^ {W{out_result_q[word_size_q]}})
			& wsli_pkg::high_mask(word_size_q)) == '0)
		else $error("result not wrapped");

	// a stalled row keeps its last cell's record
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(chain[N].valid))
		else $error("chain moved during stall");

endmodule

>>> hw/rtl/wsli_front.sv
// front stages: logic, shift, add/sub, partial products, divider setup
// depends on wsli_pkg
`timescale 1ns / 1ps

module wsli_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [3:0]                        action,
	input  logic [wsli_pkg::DataWidth-1:0]    operand_a,
	input  logic [wsli_pkg::DataWidth-1:0]    operand_b,
	input  logic [wsli_pkg::WsWidth-1:0]      word_size,
	output wsli_pkg::div_rec_t                rec
);
	localparam int unsigned W = wsli_pkg::DataWidth;
	localparam int unsigned H = W / 2;

	logic         b_neg, big;
	logic [W-1:0] cnt, a_m, a_mag, res, shl_v, shr_v, sra_v, shl_a;
	logic [5:0]   sh;

	logic         valid_s1, is_mul_s1, is_div_s1, q_neg_s1, dz_s1;
	logic [W-1:0] res_s1, p0_s1, a_mag_s1, dvs_s1;
	logic [H-1:0] p1_s1, p2_s1;
	wsli_pkg::div_rec_t rec_s2;

	always_comb begin
		b_neg = operand_b[W-1];
		cnt   = b_neg ? (~operand_b + 1'b1) : operand_b;
		big   = |cnt[W-1:6];
		sh    = cnt[5:0];
		a_m   = operand_a & ~wsli_pkg::high_mask(word_size);
		a_mag = operand_a[W-1] ? (~operand_a + 1'b1) : operand_a;
		shl_v = big ? '0 : (a_m << sh);
		shr_v = big ? '0 : (a_m >> sh);
		shl_a = big ? '0 : (operand_a << sh);
		sra_v = big ? {W{operand_a[W-1]}} : W'($signed(operand_a) >>> sh);
		case (action)
			wsli_pkg::ACT_OR:  res = operand_a | operand_b;
			wsli_pkg::ACT_AND: res = operand_a & operand_b;
			wsli_pkg::ACT_XOR: res = operand_a ^ operand_b;
			wsli_pkg::ACT_LSL: res = b_neg ? shr_v : shl_v;
			wsli_pkg::ACT_LSR: res = b_neg ? shl_v : shr_v;
			wsli_pkg::ACT_ASR: res = b_neg ? shl_a : sra_v;
			wsli_pkg::ACT_ADD: res = operand_a + operand_b;
			wsli_pkg::ACT_SUB: res = operand_a - operand_b;
			default:           res = '0;
		endcase
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			is_mul_s1 <= (action == wsli_pkg::ACT_MUL);
			is_div_s1 <= (action == wsli_pkg::ACT_DIV);
			q_neg_s1  <= operand_a[W-1] ^ b_neg;
			dz_s1     <= (operand_b == '0);
			res_s1    <= res;
			p0_s1     <= operand_a[H-1:0] * operand_b[H-1:0];
			p1_s1     <= H'(operand_a[H-1:0] * operand_b[W-1:H]);
			p2_s1     <= H'(operand_a[W-1:H] * operand_b[H-1:0]);
			a_mag_s1  <= a_mag;
			dvs_s1    <= cnt;
		end
	end

	// stage 2: finish the low product, load the divider record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_s2 <= '0;
		end else if (en) begin
			rec_s2.valid  <= valid_s1;
			rec_s2.is_div <= is_div_s1;
			rec_s2.q_neg  <= q_neg_s1;
			rec_s2.dz     <= dz_s1 & is_div_s1;
			rec_s2.rem    <= '0;
			rec_s2.dvs    <= dvs_s1;
			if (is_mul_s1) begin
				rec_s2.quo <= p0_s1 + {p1_s1 + p2_s1, {H{1'b0}}};
			end else if (is_div_s1) begin
				rec_s2.quo <= a_mag_s1;
			end else begin
				rec_s2.quo <= res_s1;
			end
		end
	end

	assign rec = rec_s2;

endmodule

>>> hw/rtl/wsli_div_cell.sv
// one restoring division step; non-divide records pass through unchanged
// depends on wsli_pkg
`timescale 1ns / 1ps

module wsli_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  wsli_pkg::div_rec_t rec_in,
	output wsli_pkg::div_rec_t rec_out
);
	localparam int unsigned W = wsli_pkg::DataWidth;

	logic [W:0]   t, diff;
	logic         ge;
	wsli_pkg::div_rec_t nxt, rec_q;

	always_comb begin
		t    = {rec_in.rem, rec_in.quo[W-1]};
		diff = t - {1'b0, rec_in.dvs};
		ge   = (t >= {1'b0, rec_in.dvs});
		nxt  = rec_in;
		if (rec_in.is_div) begin
			nxt.rem = ge ? diff[W-1:0] : t[W-1:0];
			nxt.quo = {rec_in.quo[W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (en) begin
			rec_q <= nxt;
		end
	end

	assign rec_out = rec_q;

endmodule

>>> tb/word_size_limited_integer_alu_top_test.sv
// self-checking testbench for the word-size limited integer alu
// depends on wsli_pkg, wsli_if and word_size_limited_integer_alu_top
`timescale 1ns / 1ps

module word_size_limited_integer_alu_top_test;

	// one result as the block should return it
	typedef struct {
		logic [63:0] value;
		logic        err;
	} alu_result_t;

	// one row of the directed table; has_ref marks a typed-in result
	typedef struct {
		logic [3:0]  act;
		logic [63:0] a;
		logic [63:0] b;
		logic        has_ref;
		logic [63:0] ref_value;
		logic        ref_err;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic word_size_we = 1'b0;
	logic [wsli_pkg::WsWidth-1:0] word_size_wdata = '0;

	wsli_op_if op_chan ();
	wsli_res_if res_chan ();

	word_size_limited_integer_alu_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.word_size_we(word_size_we),
		.word_size_wdata(word_size_wdata),
		.op_chan(op_chan.sink),
		.res_chan(res_chan.source)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// word size as the model of the block sees it
	logic [5:0] cur_ws;
	alu_result_t pending_results[$];
	int errors = 0;
	int results_seen = 0;
	int requests_sent = 0;
	// receiver hold-off request, raised by the stimulus process
	bit long_stall = 1'b0;
	int div_zero_seen = 0;

	function automatic logic [63:0] sign_wrap(input logic [63:0] v, input logic [5:0] w);
		logic [63:0] hi;
		hi = ~64'd0 << w;
		hi = hi << 1;
		return v[w] ? (v | hi) : (v & ~hi);
	endfunction

	function automatic logic [63:0] abs64(input logic [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	// predicted result of one request at word size w
	function automatic alu_result_t alu_predict(input logic [3:0] act, input logic [63:0] a,
			input logic [63:0] b, input logic [5:0] w);
		alu_result_t r;
		logic [63:0] cnt, am, q, raw;
		logic big;
		cnt = abs64(b);
		big = (cnt >= 64);
		am = (w == 6'd63) ? a : (a & ((64'd1 << (w + 1)) - 64'd1));
		r.err = 1'b0;
		raw = '0;
		case (act)
			wsli_pkg::ACT_OR:  raw = a | b;
			wsli_pkg::ACT_AND: raw = a & b;
			wsli_pkg::ACT_XOR: raw = a ^ b;
			wsli_pkg::ACT_LSL:
				raw = big ? 64'd0 : (b[63] ? (am >> cnt[5:0]) : (am << cnt[5:0]));
			wsli_pkg::ACT_LSR:
				raw = big ? 64'd0 : (b[63] ? (am << cnt[5:0]) : (am >> cnt[5:0]));
			wsli_pkg::ACT_ASR: begin
				if (b[63])
					raw = big ? 64'd0 : (a << cnt[5:0]);
				else if (big)
					raw = {64{a[63]}};
				else
					raw = $signed(a) >>> cnt[5:0];
			end
			wsli_pkg::ACT_ADD: raw = a + b;
			wsli_pkg::ACT_SUB: raw = a - b;
			wsli_pkg::ACT_MUL: raw = a * b;
			wsli_pkg::ACT_DIV: begin
				if (b == 0) begin
					r.err = 1'b1;
				end else begin
					q = abs64(a) / cnt;
					raw = (a[63] != b[63]) ? (~q + 64'd1) : q;
				end
			end
			default: raw = '0;
		endcase
		// unused codes and divide by zero give zero, which wraps to zero anyway
		r.value = sign_wrap(raw, w);
		return r;
	endfunction

	// one random 64-bit operand, biased toward small values and edges
	function automatic logic [63:0] rand_operand();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		case ($urandom_range(0, 7))
			0: v = {32'd0, $urandom_range(0, 70)};
			1: v = -$signed({32'd0, $urandom_range(0, 70)});
			2: v = 64'h8000_0000_0000_0000;
			3: v = 64'h7fff_ffff_ffff_ffff;
			4: v = {{48{v[15]}}, v[15:0]};
			default: ;
		endcase
		return v;
	endfunction

	// drive the register, only while no request is in flight
	task automatic set_word_size(input logic [5:0] w);
		op_chan.valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (4) @(posedge clk);
		word_size_we <= 1'b1;
		word_size_wdata <= w;
		@(posedge clk);
		word_size_we <= 1'b0;
		cur_ws = w;
	endtask

	// offer one request and wait for it to be taken; valid stays high for a
	// back-to-back follower and drops only when an idle gap is drawn
	task automatic send_request(input logic [3:0] act, input logic [63:0] a, input logic [63:0] b);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0;
		if (gap != 0) begin
			op_chan.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op_chan.valid <= 1'b1;
		op_chan.action <= act;
		op_chan.operand_a <= a;
		op_chan.operand_b <= b;
		pending_results.push_back(alu_predict(act, a, b, cur_ws));
		@(posedge clk);
		while (!op_chan.ready) @(posedge clk);
		requests_sent++;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold;
		bit stall_taken;
		res_chan.ready = 1'b0;
		stall_taken = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_stall && !stall_taken) begin
				stall_taken = 1'b1;
				res_chan.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			hold = $urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0;
			if (hold != 0) begin
				res_chan.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			res_chan.ready <= 1'b1;
		end
	end

	// checker: compare each taken result with the oldest prediction
	always @(posedge clk) begin
		alu_result_t want;
		if (arst_n && res_chan.valid && res_chan.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing pending, actual %h/%b", $time,
					res_chan.result_value, res_chan.error_code);
			end else begin
				want = pending_results.pop_front();
				if (want.value !== res_chan.result_value) begin
					errors++;
					$display("%0t: result_value expected %h actual %h", $time, want.value,
						res_chan.result_value);
				end
				if (want.err !== res_chan.error_code) begin
					errors++;
					$display("%0t: error_code expected %b actual %b", $time, want.err,
						res_chan.error_code);
				end
				if (want.err) div_zero_seen++;
			end
		end
	end

	vector_t table_rows[$];

	// add a directed row; typed-in result overrides the predictor
	function automatic void add_row(input logic [3:0] act, input logic [63:0] a,
			input logic [63:0] b, input logic has_ref, input logic [63:0] rv, input logic re);
		vector_t v;
		v.act = act; v.a = a; v.b = b;
		v.has_ref = has_ref; v.ref_value = rv; v.ref_err = re;
		table_rows.push_back(v);
	endfunction

	localparam logic [63:0] MinV = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MaxV = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] AllOnes = ~64'd0;

	initial begin
		logic [5:0] ws_list[6];
		alu_result_t typed;
		int n;
		op_chan.valid = 1'b0;
		op_chan.action = '0;
		op_chan.operand_a = '0;
		op_chan.operand_b = '0;
		cur_ws = wsli_pkg::WordSizeReset;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at reset word size 63
		add_row(wsli_pkg::ACT_OR, MinV, 64'd1, 1'b1, 64'h8000_0000_0000_0001, 1'b0);
		add_row(wsli_pkg::ACT_AND, AllOnes, MaxV, 1'b1, MaxV, 1'b0);
		add_row(wsli_pkg::ACT_XOR, AllOnes, MaxV, 1'b1, MinV, 1'b0);
		add_row(wsli_pkg::ACT_LSL, 64'd1, 64'd63, 1'b1, MinV, 1'b0);
		add_row(wsli_pkg::ACT_LSL, 64'd1, 64'd64, 1'b1, 64'd0, 1'b0);
		// negative count shifts right
		add_row(wsli_pkg::ACT_LSL, MinV, -64'sd63, 1'b1, 64'd1, 1'b0);
		add_row(wsli_pkg::ACT_LSR, MinV, 64'd63, 1'b1, 64'd1, 1'b0);
		add_row(wsli_pkg::ACT_LSR, 64'd1, -64'sd3, 1'b1, 64'd8, 1'b0);
		add_row(wsli_pkg::ACT_LSR, AllOnes, MinV, 1'b1, 64'd0, 1'b0);
		add_row(wsli_pkg::ACT_ASR, MinV, 64'd100, 1'b1, AllOnes, 1'b0);
		add_row(wsli_pkg::ACT_ASR, MaxV, 64'd64, 1'b1, 64'd0, 1'b0);
		add_row(wsli_pkg::ACT_ASR, 64'd3, -64'sd2, 1'b1, 64'd12, 1'b0);
		add_row(wsli_pkg::ACT_ASR, MinV, 64'd4, 1'b0, '0, 1'b0);
		add_row(wsli_pkg::ACT_ADD, MaxV, 64'd1, 1'b1, MinV, 1'b0);
		add_row(wsli_pkg::ACT_SUB, MinV, 64'd1, 1'b1, MaxV, 1'b0);
		add_row(wsli_pkg::ACT_MUL, MaxV, MaxV, 1'b1, 64'd1, 1'b0);
		add_row(wsli_pkg::ACT_MUL, 64'h1234_5678_9abc_def0, -64'sd7, 1'b0, '0, 1'b0);
		// divide by zero
		add_row(wsli_pkg::ACT_DIV, 64'd5, 64'd0, 1'b1, 64'd0, 1'b1);
		// most negative over minus one
		add_row(wsli_pkg::ACT_DIV, MinV, AllOnes, 1'b1, MinV, 1'b0);
		// truncation toward zero
		add_row(wsli_pkg::ACT_DIV, -64'sd7, 64'd2, 1'b1, -64'sd3, 1'b0);
		add_row(wsli_pkg::ACT_DIV, MaxV, MinV, 1'b1, 64'd0, 1'b0);
		add_row(4'd10, MaxV, MaxV, 1'b1, 64'd0, 1'b0);      // unused code
		add_row(4'd15, AllOnes, AllOnes, 1'b1, 64'd0, 1'b0);
		foreach (table_rows[i]) begin
			send_request(table_rows[i].act, table_rows[i].a, table_rows[i].b);
			if (table_rows[i].has_ref) begin
				typed.value = table_rows[i].ref_value;
				typed.err = table_rows[i].ref_err;
				// the typed-in result replaces the prediction for this row
				void'(pending_results.pop_back());
				pending_results.push_back(typed);
			end
		end

		// random part across several word sizes, extremes included
		ws_list = '{6'd1, 6'd63, 6'd7, 6'd31, 6'd0, 6'($urandom_range(2, 62))};
		foreach (ws_list[k]) begin
			set_word_size(ws_list[k]);
			n = (k == 4) ? 40 : 100;
			for (int i = 0; i < n; i++) begin
				if (k == 1 && i == 10) long_stall = 1'b1;
				send_request(4'($urandom_range(0, 15) < 14 ? $urandom_range(0, 9)
					: $urandom_range(10, 15)), rand_operand(), rand_operand());
			end
		end
		op_chan.valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (100) @(posedge clk);
		$display("sent %0d requests, checked %0d results (%0d divide-by-zero)",
			requests_sent, results_seen, div_zero_seen);
		$display("word sizes 0, 1, 7, 31, 63 and one random size, with long output stall");
		if (errors == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// overall time limit
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
